>>> rtl/ehbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ehbf_pkg;

  localparam int COORD_W = 19;
  localparam int CNT_W   = 20;
  localparam int DIV_W   = 16;
  localparam int GAP_W   = 11;
  localparam int SQ_W    = 38;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = 34;
  localparam int CX_W    = 34;
  localparam int ANG_W   = 26;
  localparam int BINW_W  = 14;
  localparam int MDEG_W  = 17;
  localparam int NUM_W   = 6;
  localparam int NBEAM_W = 7;
  localparam int STEP_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 22;
  localparam int DIV_STEPS    = 20;

  localparam logic signed [ANG_W-1:0] ANG_LO = -26'sd3276800;
  localparam logic signed [ANG_W-1:0] ANG_HI = 26'sd2457600;
  localparam logic [CNT_W-1:0] CNT_MAX = 20'hFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DIV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP  = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic sqrt_step;
    logic cord_init;
    logic cord_step;
    logic bin_calc;
    logic hist_rd;
    logic hist_inc;
    logic div_init;
    logic div_step;
    logic scan_start;
    logic scan_run;
    logic finish;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic scan_done;
    logic frame_end;
  } sts_t;

  // atan(2^-i) in units of 1/81920 degree
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd3686400;
      5'd1:  v = 26'sd2176209;
      5'd2:  v = 26'sd1149849;
      5'd3:  v = 26'sd583681;
      5'd4:  v = 26'sd292973;
      5'd5:  v = 26'sd146629;
      5'd6:  v = 26'sd73333;
      5'd7:  v = 26'sd36669;
      5'd8:  v = 26'sd18335;
      5'd9:  v = 26'sd9167;
      5'd10: v = 26'sd4584;
      5'd11: v = 26'sd2292;
      5'd12: v = 26'sd1146;
      5'd13: v = 26'sd573;
      5'd14: v = 26'sd286;
      5'd15: v = 26'sd143;
      5'd16: v = 26'sd72;
      5'd17: v = 26'sd36;
      5'd18: v = 26'sd18;
      5'd19: v = 26'sd9;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ehbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ehbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ehbf_pkg::sts_t sts,
  output ehbf_pkg::cmd_t     cmd
);
  import ehbf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_SQRT, S_CINIT, S_CORD, S_BIN, S_RD, S_INC,
    S_DINIT, S_DIV, S_THR, S_SCAN, S_FIN
  } state_t;

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.step = step;
    state_next = state;
    step_next = step;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        step_next = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          step_next = '0;
          state_next = S_CINIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        step_next = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          step_next = '0;
          state_next = S_BIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_BIN: begin
        cmd.bin_calc = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.hist_rd = 1'b1;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.hist_inc = 1'b1;
        state_next = sts.frame_end ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next = '0;
          state_next = S_THR;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_THR: begin
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (sts.adv) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // reset lands in the scan so the histogram gets swept to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SCAN;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ehbf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ehbf_datapath #(
  parameter int HIST_BINS = 1401,
  parameter int MAX_BEAMS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ehbf_pkg::cmd_t                     cmd,
  output ehbf_pkg::sts_t                          sts,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] x_mm,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] y_mm,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] z_mm,
  input  wire logic                               frame_end,
  input  wire logic [ehbf_pkg::CNT_W-1:0]         min_frame_points,
  input  wire logic [ehbf_pkg::CNT_W-1:0]         peak_floor,
  input  wire logic [ehbf_pkg::DIV_W-1:0]         peak_divisor,
  input  wire logic [ehbf_pkg::GAP_W-1:0]         merge_gap_bins,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    beam_present,
  output logic [ehbf_pkg::NUM_W-1:0]              beam_number,
  output logic signed [ehbf_pkg::MDEG_W-1:0]      elevation_mdeg,
  output logic                                    last,
  output logic                                    truncated
);
  import ehbf_pkg::*;

  localparam int BW = $clog2(HIST_BINS);
  localparam int AW = $clog2(HIST_BINS + 1);
  localparam int DW = (BW > GAP_W) ? BW : GAP_W;

  // point front end
  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic                      fe_r;
  logic [CNT_W-1:0]          pt_cnt;
  logic signed [SQ_W-1:0]    xp, yp;
  logic [SQ_W-2:0]           xx, yy;
  logic [RAD_W-1:0]          rad;
  logic [REM_W-1:0]          rem, rem_s;
  logic [ROOT_W-1:0]         root;
  logic [REM_W-1:0]          trial;
  logic signed [CX_W-1:0]    cx, cy;
  logic signed [ANG_W-1:0]   ang, ang_e, off;
  logic                      zflag;
  logic [BINW_W-1:0]         binw;
  logic [BW-1:0]             bin_idx;
  logic                      bin_ok;

  // histogram memory
  logic [CNT_W-1:0] hist [HIST_BINS];
  logic [CNT_W-1:0] rdata, wdata;
  logic [BW-1:0]    raddr, waddr;
  logic             mem_re, mem_we;

  // threshold divider
  logic [CNT_W-1:0] dq, thr;
  logic [DIV_W:0]   dr, rs;
  logic [DIV_W-1:0] dv;
  logic             emit_en;

  // scan pipeline
  logic [AW-1:0]    saddr;
  logic             v1, v2;
  logic [BW-1:0]    a1, a2, c;
  logic [CNT_W-1:0] w0, w1, w2;
  logic             have, trunc;
  logic [GAP_W-1:0] last_bin;
  logic [NBEAM_W-1:0] nbeam;
  logic             pend_v;
  logic [NUM_W-1:0] pend_num;
  logic [MDEG_W-1:0] pend_mdeg;
  logic             adv, issue, is_peak, take;
  logic             out_load;
  logic [DW-1:0]    diff;
  logic [31:0]      mdeg_w;

  assign adv = !out_valid || !out_stall;
  assign issue = cmd.scan_run && adv && (saddr != AW'(HIST_BINS));
  assign sts.adv = adv;
  assign sts.scan_done = (saddr == AW'(HIST_BINS)) && !v1 && !v2;
  assign sts.frame_end = fe_r;

  assign xp = SQ_W'(x_r) * SQ_W'(x_r);
  assign yp = SQ_W'(y_r) * SQ_W'(y_r);

  assign rem_s = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial = REM_W'({root, 2'b01});

  assign ang_e = zflag ? '0 : ang;
  assign off = ang_e - ANG_LO;
  assign binw = off[ANG_W-1:12];

  assign rs = {dr[DIV_W-1:0], dq[CNT_W-1]};
  assign dv = (peak_divisor == '0) ? DIV_W'(1) : peak_divisor;

  assign c = a2 - BW'(1);
  assign is_peak = v2 && (a2 >= BW'(2)) && (w1 > w0) && (w1 >= w2) && (w1 > thr);
  assign diff = DW'(c) - DW'(last_bin);
  assign take = is_peak && !(have && (diff < DW'(merge_gap_bins)));
  assign mdeg_w = 32'(c) * 32'd50 - 32'd39975;

  // a new beam pushes the previous one out (not last); finish sends the last record
  assign out_load = (adv && cmd.scan_run && emit_en && take &&
                     nbeam < NBEAM_W'(MAX_BEAMS) && pend_v) ||
                    (cmd.finish && adv && emit_en);

  // point path: square, root, angle, bin
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= x_mm;
      y_r <= y_mm;
      z_r <= z_mm;
    end
    if (cmd.mul) begin
      xx <= xp[SQ_W-2:0];
      yy <= yp[SQ_W-2:0];
    end
    if (cmd.sum) begin
      rad <= {SQ_W'(xx) + SQ_W'(yy), 24'b0};
      rem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem <= rem_s - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_s;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.cord_init) begin
      cx <= CX_W'(root);
      cy <= CX_W'(z_r) <<< 12;
      ang <= '0;
      zflag <= (root == '0) && (z_r == '0);
    end
    if (cmd.cord_step) begin
      if (cy > 0) begin
        cx <= cx + (cy >>> cmd.step);
        cy <= cy - (cx >>> cmd.step);
        ang <= ang + atan_lut(cmd.step);
      end else begin
        cx <= cx - (cy >>> cmd.step);
        cy <= cy + (cx >>> cmd.step);
        ang <= ang - atan_lut(cmd.step);
      end
    end
    if (cmd.bin_calc) begin
      bin_idx <= binw[BW-1:0];
      bin_ok <= (ang_e >= ANG_LO) && (ang_e <= ANG_HI) && (binw < BINW_W'(HIST_BINS));
    end
  end

  // histogram port: read and clear during the sweep, read-modify-write per point
  always_comb begin
    mem_re = cmd.hist_rd || issue;
    mem_we = issue || (cmd.hist_inc && bin_ok);
    raddr = cmd.scan_run ? saddr[BW-1:0] : bin_idx;
    waddr = raddr;
    if (cmd.scan_run) wdata = '0;
    else wdata = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist[waddr] <= wdata;
    if (mem_re) rdata <= hist[raddr];
  end

  // divider for count / divisor
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq <= pt_cnt;
      dr <= '0;
    end
    if (cmd.div_step) begin
      if (rs >= {1'b0, dv}) begin
        dr <= rs - {1'b0, dv};
        dq <= {dq[CNT_W-2:0], 1'b1};
      end else begin
        dr <= rs;
        dq <= {dq[CNT_W-2:0], 1'b0};
      end
    end
    if (cmd.scan_start) thr <= (dq > peak_floor) ? dq : peak_floor;
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.scan_run) begin
      if (v1) begin
        w0 <= w1;
        w1 <= w2;
        w2 <= rdata;
      end
      a2 <= a1;
      if (issue) a1 <= saddr[BW-1:0];
    end
    if (adv && cmd.scan_run && emit_en && take && nbeam < NBEAM_W'(MAX_BEAMS)) begin
      pend_num <= nbeam[NUM_W-1:0];
      pend_mdeg <= mdeg_w[MDEG_W-1:0];
    end
    if (adv && cmd.scan_run && emit_en && take && nbeam < NBEAM_W'(MAX_BEAMS) && pend_v) begin
      beam_present <= 1'b1;
      beam_number <= pend_num;
      elevation_mdeg <= pend_mdeg;
      last <= 1'b0;
      truncated <= 1'b0;
    end
    if (cmd.finish && adv && emit_en) begin
      beam_present <= pend_v;
      beam_number <= pend_v ? pend_num : '0;
      elevation_mdeg <= pend_v ? pend_mdeg : '0;
      last <= 1'b1;
      truncated <= pend_v && trunc;
    end
  end

  // control state of the scan and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fe_r <= 1'b0;
      pt_cnt <= '0;
      emit_en <= 1'b0;
      saddr <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      have <= 1'b0;
      trunc <= 1'b0;
      last_bin <= '0;
      nbeam <= '0;
      pend_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.load) begin
        fe_r <= frame_end;
        if (pt_cnt != CNT_MAX) pt_cnt <= pt_cnt + 1'b1;
      end
      if (cmd.div_init) emit_en <= (pt_cnt >= min_frame_points);
      if (cmd.scan_start) begin
        pt_cnt <= '0;
        saddr <= '0;
        v1 <= 1'b0;
        v2 <= 1'b0;
        have <= 1'b0;
        trunc <= 1'b0;
        last_bin <= '0;
        nbeam <= '0;
        pend_v <= 1'b0;
      end
      if (adv && cmd.scan_run) begin
        v1 <= issue;
        v2 <= v1;
        if (issue) saddr <= saddr + 1'b1;
        if (emit_en && take) begin
          have <= 1'b1;
          last_bin <= GAP_W'(c);
          if (nbeam < NBEAM_W'(MAX_BEAMS)) begin
            nbeam <= nbeam + 1'b1;
            pend_v <= 1'b1;
          end else begin
            trunc <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/elevation_histogram_beam_finder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Points are taken one at a time: after an accept, in_stall stays high until the point has
// passed 31 root steps, 22 CORDIC steps and a histogram read-modify-write on one memory port.
// A frame-end point adds a threshold division and a histogram sweep, plus any time the
// output side stalls; beams leave during the sweep and the last record after it.
// Reset: synchronous; afterwards the histogram is cleared by a sweep during which in_stall
// stays high. Configuration returns to its defaults.
module elevation_histogram_beam_finder_top #(
  parameter int HIST_BINS = 1401,
  parameter int MAX_BEAMS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] x_mm,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] y_mm,
  input  wire logic signed [ehbf_pkg::COORD_W-1:0] z_mm,
  input  wire logic                                frame_end,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     beam_present,
  output logic [ehbf_pkg::NUM_W-1:0]               beam_number,
  output logic signed [ehbf_pkg::MDEG_W-1:0]       elevation_mdeg,
  output logic                                     last,
  output logic                                     truncated,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ehbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ehbf_pkg::CNT_W-1:0]          cfg_data
);
  import ehbf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [CNT_W-1:0] min_frame_points, peak_floor;
  logic [DIV_W-1:0] peak_divisor;
  logic [GAP_W-1:0] merge_gap_bins;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_points <= CNT_W'(1000);
      peak_floor <= CNT_W'(5);
      peak_divisor <= DIV_W'(2500);
      merge_gap_bins <= GAP_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_POINTS: min_frame_points <= cfg_data;
        CFG_PEAK_FLOOR: peak_floor <= cfg_data;
        CFG_PEAK_DIV:   peak_divisor <= cfg_data[DIV_W-1:0];
        CFG_MERGE_GAP:  merge_gap_bins <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  ehbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ehbf_datapath #(
    .HIST_BINS (HIST_BINS),
    .MAX_BEAMS (MAX_BEAMS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .x_mm             (x_mm),
    .y_mm             (y_mm),
    .z_mm             (z_mm),
    .frame_end        (frame_end),
    .min_frame_points (min_frame_points),
    .peak_floor       (peak_floor),
    .peak_divisor     (peak_divisor),
    .merge_gap_bins   (merge_gap_bins),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .beam_present     (beam_present),
    .beam_number      (beam_number),
    .elevation_mdeg   (elevation_mdeg),
    .last             (last),
    .truncated        (truncated)
  );

endmodule
`default_nettype wire
